@@ design/tag_dedup_slip_encoder_core_defines.svh @@
// Assertion macros used by the core design file.
`ifndef TAG_DEDUP_SLIP_ENCODER_CORE_DEFINES_SVH
`define TAG_DEDUP_SLIP_ENCODER_CORE_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define TDSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define TDSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/tdse_pkg.sv @@
package tdse_pkg;

  localparam int unsigned TagW = 96;
  localparam logic [7:0] FrEnd    = 8'hC0;
  localparam logic [7:0] FrEsc    = 8'hDB;
  localparam logic [7:0] FrEscEnd = 8'hDC;
  localparam logic [7:0] FrEscEsc = 8'hDD;
  localparam logic [3:0] LastByte = 4'd11;

  typedef struct packed {
    logic        operation;
    logic [31:0] tag_id_high;
    logic [63:0] tag_id_low;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       lost_tags;
  } out_t;

  // Search token that walks down the row of cells.
  typedef struct packed {
    logic valid;
    logic hit;
  } tok_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SEND,
    ST_ESC
  } state_e;

endpackage

@@ design/tdse_cell.sv @@
module tdse_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [tdse_pkg::TagW-1:0] key_i,
  input  logic                     we_i,
  input  logic                     occ_i,
  input  tdse_pkg::tok_t           tok_i,
  output tdse_pkg::tok_t           tok_o
);
  import tdse_pkg::*;

  logic [TagW-1:0] entry_q;
  tok_t            tok_q, tok_d;

  always_comb begin
    tok_d.valid = tok_i.valid;
    tok_d.hit   = tok_i.hit | (tok_i.valid & occ_i & (entry_q == key_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      entry_q <= key_i;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ design/tag_dedup_slip_encoder_core.sv @@
// A frame end gives its byte in the cycle after start. A tag is compared as a
// token walks the row of cells; a new tag then sends 12 to 24 bytes at one per
// cycle, and a repeat or a tag that finds the store full sends none.
// One item is in work at a time; a new item is taken only while idle.
// Reset clears the store count, the lost flag and control; no clearing pass.
// The receiver cannot stall: each byte is shown for exactly one cycle.
`include "tag_dedup_slip_encoder_core_defines.svh"

module tag_dedup_slip_encoder_core #(
  parameter int unsigned MAX_TAGS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  tdse_pkg::in_t  item_i,
  output logic           strobe_o,
  output tdse_pkg::out_t result_o
);
  import tdse_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_TAGS + 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            lost_q, lost_d;
  logic            launch_q, launch_d;
  logic [TagW-1:0] key_q, key_d;
  logic [3:0]      idx_q, idx_d;
  logic [7:0]      esc_q, esc_d;
  logic            strobe_q, strobe_d;
  out_t            res_q, res_d;
  logic            wr_en;
  logic            accept;
  logic [7:0]      cur_byte;

  tok_t            tok [MAX_TAGS+1];

  assign accept   = start && (state_q == ST_IDLE);
  assign cur_byte = key_q[TagW-1 -: 8];
  assign tok[0]   = '{valid: launch_q, hit: 1'b0};

  for (genvar i = 0; i < MAX_TAGS; i++) begin : g_cell
    tdse_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .key_i  (key_q),
      .we_i   (wr_en && (cnt_q == CntW'(i))),
      .occ_i  (CntW'(i) < cnt_q),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    lost_d   = lost_q;
    launch_d = 1'b0;
    key_d    = key_q;
    idx_d    = idx_q;
    esc_d    = esc_q;
    strobe_d = 1'b0;
    res_d    = res_q;
    wr_en    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (item_i.operation) begin
            strobe_d = 1'b1;
            res_d    = '{out_byte: FrEnd, last: 1'b1, lost_tags: lost_q};
            cnt_d    = '0;
            lost_d   = 1'b0;
          end else begin
            key_d    = {item_i.tag_id_high, item_i.tag_id_low};
            launch_d = 1'b1;
            state_d  = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (tok[MAX_TAGS].valid) begin
          if (tok[MAX_TAGS].hit) begin
            state_d = ST_IDLE;
          end else if (cnt_q == CntW'(MAX_TAGS)) begin
            lost_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            wr_en   = 1'b1;
            cnt_d   = cnt_q + CntW'(1);
            idx_d   = '0;
            state_d = ST_SEND;
          end
        end
      end
      ST_SEND: begin
        strobe_d = 1'b1;
        if ((cur_byte == FrEnd) || (cur_byte == FrEsc)) begin
          res_d   = '{out_byte: FrEsc, last: 1'b0, lost_tags: 1'b0};
          esc_d   = (cur_byte == FrEnd) ? FrEscEnd : FrEscEsc;
          state_d = ST_ESC;
        end else begin
          res_d = '{out_byte: cur_byte, last: (idx_q == LastByte), lost_tags: 1'b0};
          key_d = {key_q[TagW-9:0], 8'h00};
          idx_d = idx_q + 4'd1;
          if (idx_q == LastByte) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_ESC: begin
        strobe_d = 1'b1;
        res_d    = '{out_byte: esc_q, last: (idx_q == LastByte), lost_tags: 1'b0};
        key_d    = {key_q[TagW-9:0], 8'h00};
        idx_d    = idx_q + 4'd1;
        state_d  = (idx_q == LastByte) ? ST_IDLE : ST_SEND;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      lost_q   <= 1'b0;
      launch_q <= 1'b0;
      strobe_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      lost_q   <= lost_d;
      launch_q <= launch_d;
      strobe_q <= strobe_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    esc_q <= esc_d;
    res_q <= res_d;
  end

  assign busy     = (state_q != ST_IDLE);
  assign strobe_o = strobe_q;
  assign result_o = res_q;

  `TDSE_ASSERT(a_cnt_range, cnt_q <= CntW'(MAX_TAGS), "store count beyond capacity")
  `TDSE_ASSERT(a_lost_end, strobe_o && result_o.lost_tags |-> result_o.last, "lost flag off end")
  `TDSE_ASSERT(a_tok_in_search, tok[MAX_TAGS].valid |-> state_q == ST_SEARCH, "stray search token")
  `TDSE_ASSERT_NEXT(a_clear, accept && item_i.operation, cnt_q == '0 && !lost_q, "not cleared")

endmodule

@@ verif/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tdse_pkg::*;

  localparam int unsigned StoreDepth = 64;
  localparam logic OpTagFound = 1'b0;
  localparam logic OpFrameEnd = 1'b1;
  localparam int unsigned RandomItems = 100;
  localparam int unsigned TailItems = 12;
  localparam int unsigned SettleCycles = StoreDepth + 90;

  typedef struct {
    in_t ev;
    bit  drain;
  } stim_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  item_i = '0;
  logic strobe_o;
  out_t result_o;

  stim_t event_q[$];
  out_t  byte_q[$];
  int unsigned mismatch_cnt = 0;

  // Shadow of the block's tag store.
  logic [TagW-1:0] seen_ids[StoreDepth];
  int unsigned seen_cnt = 0;
  bit dropped_flag = 1'b0;

  tag_dedup_slip_encoder_core #(
    .MAX_TAGS(StoreDepth)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .strobe_o(strobe_o),
    .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Works out the byte stream that one accepted event causes.
  task automatic encode_event(input in_t ev);
    logic [TagW-1:0] id;
    logic [7:0] b;
    bit fin;
    if (ev.operation == OpFrameEnd) begin
      byte_q.push_back(out_t'{out_byte: FrEnd, last: 1'b1, lost_tags: dropped_flag});
      seen_cnt = 0;
      dropped_flag = 1'b0;
      return;
    end
    id = {ev.tag_id_high, ev.tag_id_low};
    for (int i = 0; i < seen_cnt; i++) begin
      if (seen_ids[i] == id) return;
    end
    if (seen_cnt >= StoreDepth) begin
      dropped_flag = 1'b1;
      return;
    end
    seen_ids[seen_cnt] = id;
    seen_cnt++;
    for (int i = 0; i < 12; i++) begin
      b = id[TagW-1-8*i -: 8];
      fin = (i == LastByte);
      if (b == FrEnd || b == FrEsc) begin
        byte_q.push_back(out_t'{out_byte: FrEsc, last: 1'b0, lost_tags: 1'b0});
        byte_q.push_back(out_t'{out_byte: (b == FrEnd) ? FrEscEnd : FrEscEsc,
                                last: fin, lost_tags: 1'b0});
      end else begin
        byte_q.push_back(out_t'{out_byte: b, last: fin, lost_tags: 1'b0});
      end
    end
  endtask

  // Random ID with the framing bytes much more likely than by chance.
  function automatic logic [TagW-1:0] rand_tag();
    logic [TagW-1:0] id;
    int unsigned pick;
    for (int i = 0; i < 12; i++) begin
      pick = $urandom_range(0, 7);
      if (pick == 0) id[8*i +: 8] = FrEnd;
      else if (pick == 1) id[8*i +: 8] = FrEsc;
      else id[8*i +: 8] = 8'($urandom());
    end
    return id;
  endfunction

  task automatic add_tag(input logic [TagW-1:0] id, input bit drain);
    stim_t s;
    s.ev.operation = OpTagFound;
    {s.ev.tag_id_high, s.ev.tag_id_low} = id;
    s.drain = drain;
    event_q.push_back(s);
  endtask

  // The ID fields of a frame end are don't-care, so they carry noise.
  task automatic add_frame_end(input bit drain);
    stim_t s;
    s.ev.operation = OpFrameEnd;
    s.ev.tag_id_high = $urandom();
    s.ev.tag_id_low = {$urandom(), $urandom()};
    s.drain = drain;
    event_q.push_back(s);
  endtask

  // Driver.
  int unsigned gap_left = 0;
  bit calm = 1'b0;
  bit slot_free;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
      item_i <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) encode_event(item_i);
      slot_free = !start || !busy;
      if (slot_free) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (event_q.size() == 0) begin
          start <= 1'b0;
        end else if (event_q[0].drain && byte_q.size() != 0) begin
          start <= 1'b0;
        end else if (event_q.size() > TailItems && !calm && $urandom_range(0, 3) == 0) begin
          gap_left <= $urandom_range(0, 16);
          start <= 1'b0;
        end else begin
          item_i <= event_q[0].ev;
          start <= 1'b1;
          void'(event_q.pop_front());
          if ($urandom_range(0, 15) == 0) calm = !calm;
        end
      end
    end
  end

  // Monitor.
  out_t want;

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o === 1'b1) begin
      if (byte_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual byte %h last %b lost %b",
                 $realtime, result_o.out_byte, result_o.last, result_o.lost_tags);
        mismatch_cnt++;
      end else begin
        want = byte_q.pop_front();
        if (result_o.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %h actual %h",
                   $realtime, want.out_byte, result_o.out_byte);
          mismatch_cnt++;
        end
        if (result_o.last !== want.last) begin
          $display("%0t: last expected %b actual %b", $realtime, want.last, result_o.last);
          mismatch_cnt++;
        end
        if (result_o.lost_tags !== want.lost_tags) begin
          $display("%0t: lost_tags expected %b actual %b",
                   $realtime, want.lost_tags, result_o.lost_tags);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    logic [TagW-1:0] frame_ids[$];
    logic [TagW-1:0] id;
    int unsigned directed_cnt;
    int unsigned distinct;
    int unsigned burst;

    // Directed part.
    add_frame_end(1'b0);
    add_tag('0, 1'b0);
    add_tag('1, 1'b0);
    add_tag({12{FrEnd}}, 1'b0);
    add_tag({12{FrEsc}}, 1'b0);
    add_tag({FrEnd, FrEsc, 8'h00, 8'hFF, FrEsc, FrEnd, 8'h7F, 8'h80,
             FrEnd, 8'h01, 8'hFE, FrEsc}, 1'b0);
    add_tag('0, 1'b0);
    add_tag({12{FrEnd}}, 1'b0);
    add_frame_end(1'b0);
    add_frame_end(1'b0);
    add_tag('0, 1'b0);
    add_frame_end(1'b1);
    add_tag({FrEscEnd, FrEscEsc, FrEscEnd, FrEscEsc, 8'hC1, 8'hDA,
             8'hBF, 8'hDE, 8'h55, 8'hAA, FrEscEsc, FrEnd}, 1'b0);
    add_tag(96'h1, 1'b0);
    add_tag(96'h1, 1'b0);
    add_frame_end(1'b0);
    directed_cnt = event_q.size();

    // Flood: overfill the store with repeats mixed in, then close the frame.
    distinct = 0;
    while (distinct < StoreDepth + 4) begin
      if (frame_ids.size() != 0 && $urandom_range(0, 4) == 0) begin
        add_tag(frame_ids[$urandom_range(0, frame_ids.size() - 1)], 1'b0);
      end else begin
        id = rand_tag();
        frame_ids.push_back(id);
        distinct++;
        add_tag(id, 1'b0);
      end
    end
    add_tag(frame_ids[0], 1'b0);
    add_frame_end(1'b1);

    // Short frames with repeats until the random budget is spent.
    while (event_q.size() < directed_cnt + RandomItems) begin
      frame_ids.delete();
      burst = $urandom_range(0, 5);
      for (int k = 0; k < burst; k++) begin
        if (frame_ids.size() != 0 && $urandom_range(0, 2) == 0) begin
          add_tag(frame_ids[$urandom_range(0, frame_ids.size() - 1)], 1'b0);
        end else begin
          id = rand_tag();
          frame_ids.push_back(id);
          add_tag(id, 1'b0);
        end
      end
      add_frame_end($urandom_range(0, 5) == 0);
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (event_q.size() != 0 || start) @(posedge clk_i);
    while (byte_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    if (mismatch_cnt == 0 && byte_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
